/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ffba_pkg.sv */
package ffba_pkg;

  localparam int ARENA_BYTES_DEF  = 256;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int MAX_SEGMENTS_DEF = 16;

  localparam int S_DATA_W = 16;
  localparam int S_USER_W = 1;
  localparam int M_DATA_W = 16;
  localparam int FIELD_W  = 8;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_MARK,
    WR_SHIFT,
    WR_TAIL,
    WR_HEAD
  } wr_sel_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_ALLOC,
    RES_FREED,
    RES_FAIL,
    RES_NULL
  } res_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     scan_start;
    logic     scan_next;
    logic     shift_start;
    logic     shift_step;
    wr_sel_t  wr_sel;
    res_sel_t res_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic in_null;
    logic op_free;
    logic hit;
    logic split;
    logic last;
    logic ptr_beyond;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/first_fit_block_allocator.sv */
// Per word: S_SCAN reads the table entries, one per cycle through the segment RAM read
//   port, then S_RESP loads the result into the output register; a null free skips S_SCAN.
// A split then moves the entries below the hit down the table, one per cycle, plus two insert writes.
// One word at a time: the next is taken once the result sits in the output register;
//   S_RESP waits while the output register still holds a word that is not yet taken.
// Reset: synchronous; while reset is held, entry 0 is written as the whole free arena, count is 1.
`include "assert_macros.svh"

module first_fit_block_allocator #(
  parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ffba_pkg::S_DATA_W-1:0] s_tdata,  // request_size, free_offset
  input  logic [ffba_pkg::S_USER_W-1:0] s_tuser,  // func
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ffba_pkg::M_DATA_W-1:0] m_tdata   // status, payload_offset
);

  import ffba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_dp #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

  `ASSERT_CLK(a_head_after_tail,
              cmd.wr_sel == WR_HEAD |-> $past(cmd.wr_sel) == WR_TAIL,
              "head write without tail write")
  `ASSERT_CLK(a_load_when_free, cmd.load_out |-> sts.out_free, "result overwrites pending word")
  `ASSERT_CLK(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second word taken during work")

endmodule

/* hw/rtl/ffba_ram.sv */
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ffba_dp.sv */
module ffba_dp #(
  parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SEGMENTS = ffba_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ffba_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic [ffba_pkg::S_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ffba_pkg::M_DATA_W-1:0]  m_tdata,
  input  ffba_pkg::cmd_t                 cmd,
  output ffba_pkg::sts_t                 sts
);

  import ffba_pkg::*;

  localparam int POS_W = $clog2(ARENA_BYTES + 1);
  localparam int CMP_W = (POS_W > FIELD_W + 1) ? POS_W : FIELD_W + 1;
  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int ENT_W = 2 * POS_W + 1;

  op_t                op;
  logic [FIELD_W-1:0] req;
  logic [FIELD_W-1:0] off;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   ptr;
  logic [CNT_W-1:0]   count;
  logic [POS_W-1:0]   hit_start;
  logic [POS_W-1:0]   hit_size;
  status_t            res_status;
  logic [FIELD_W-1:0] res_off;
  status_t            out_status;
  logic [FIELD_W-1:0] out_off;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENT_W-1:0]   wdata;
  logic [IDX_W-1:0]   raddr;
  logic [ENT_W-1:0]   rdata;

  logic [POS_W-1:0]   rd_start;
  logic [POS_W-1:0]   rd_size;
  logic               rd_free;
  logic [CMP_W-1:0]   need;
  logic [CMP_W-1:0]   size_c;
  logic [CMP_W-1:0]   start_h;
  logic [CMP_W-1:0]   tail_start;
  logic [CMP_W-1:0]   tail_size;
  logic [CNT_W-1:0]   idx_ext;
  logic [CNT_W-1:0]   ptr_ext;
  logic [CNT_W-1:0]   cnt_m1;
  logic               alloc_hit;
  logic               free_hit;
  logic               room;

  assign rd_start = rdata[POS_W-1:0];
  assign rd_size  = rdata[2*POS_W-1:POS_W];
  assign rd_free  = rdata[ENT_W-1];

  assign need       = CMP_W'(req) + CMP_W'(HEADER_BYTES);
  assign size_c     = CMP_W'(rd_size);
  assign start_h    = CMP_W'(rd_start) + CMP_W'(HEADER_BYTES);
  assign tail_start = CMP_W'(hit_start) + need;
  assign tail_size  = CMP_W'(hit_size) - need;
  assign idx_ext    = CNT_W'(idx);
  assign ptr_ext    = CNT_W'(ptr);
  assign cnt_m1     = count - CNT_W'(1);
  assign room       = (count != CNT_W'(MAX_SEGMENTS));

  assign alloc_hit = rd_free && (size_c >= need);
  assign free_hit  = (start_h == CMP_W'(off));

  assign sts.in_null    = (op_t'(s_tuser[0]) == OP_FREE) &&
                          (s_tdata[2*FIELD_W-1:FIELD_W] == '0);
  assign sts.op_free    = (op == OP_FREE);
  assign sts.hit        = (op == OP_FREE) ? free_hit : alloc_hit;
  assign sts.split      = (op == OP_ALLOC) && (size_c > need) && room;
  assign sts.last       = (idx_ext + CNT_W'(1) >= count);
  assign sts.ptr_beyond = (ptr_ext > idx_ext + CNT_W'(1));
  assign sts.out_free   = !m_tvalid || m_tready;

  always_comb begin
    raddr = '0;
    if (cmd.scan_next) begin
      raddr = idx + IDX_W'(1);
    end else if (cmd.shift_start) begin
      raddr = cnt_m1[IDX_W-1:0];
    end else if (cmd.shift_step) begin
      raddr = ptr - IDX_W'(1);
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = '0;
    wdata = {1'b1, POS_W'(ARENA_BYTES - HEADER_BYTES), POS_W'(0)};
    if (!rst) begin
      case (cmd.wr_sel)
        WR_MARK: begin
          waddr = idx;
          wdata = {(op == OP_FREE), rd_size, rd_start};
        end
        WR_SHIFT: begin
          waddr = ptr + IDX_W'(1);
          wdata = rdata;
        end
        WR_TAIL: begin
          waddr = idx + IDX_W'(1);
          wdata = {1'b1, tail_size[POS_W-1:0], tail_start[POS_W-1:0]};
        end
        WR_HEAD: begin
          waddr = idx;
          wdata = {1'b0, POS_W'(req), hit_start};
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  ffba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op  <= op_t'(s_tuser[0]);
      req <= s_tdata[FIELD_W-1:0];
      off <= s_tdata[2*FIELD_W-1:FIELD_W];
    end
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.scan_next) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.shift_start) begin
      ptr <= cnt_m1[IDX_W-1:0];
    end else if (cmd.shift_step) begin
      ptr <= ptr - IDX_W'(1);
    end
    if (cmd.res_sel == RES_ALLOC) begin
      hit_start <= rd_start;
      hit_size  <= rd_size;
    end
    case (cmd.res_sel)
      RES_ALLOC: begin
        res_status <= ST_OK;
        res_off    <= start_h[FIELD_W-1:0];
      end
      RES_FREED: begin
        res_status <= ST_OK;
        res_off    <= '0;
      end
      RES_FAIL: begin
        res_status <= (op == OP_FREE) ? ST_NOTFOUND : ST_NOFIT;
        res_off    <= '0;
      end
      RES_NULL: begin
        res_status <= ST_NULL;
        res_off    <= '0;
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_status <= res_status;
      out_off    <= res_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= CNT_W'(1);
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.wr_sel == WR_HEAD) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(M_DATA_W - FIELD_W - 2)'(0), out_off, out_status};

endmodule

/* hw/rtl/ffba_ctrl.sv */
module ffba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  ffba_pkg::sts_t sts,
  output ffba_pkg::cmd_t cmd
);

  import ffba_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_TAIL  = 6'b001000,
    S_HEAD  = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wr_sel  = WR_NONE;
    cmd.res_sel = RES_NONE;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          if (sts.in_null) begin
            cmd.res_sel = RES_NULL;
            state_next  = S_RESP;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.res_sel = sts.op_free ? RES_FREED : RES_ALLOC;
          if (sts.split) begin
            if (!sts.last) begin
              cmd.shift_start = 1'b1;
              state_next      = S_SHIFT;
            end else begin
              state_next = S_TAIL;
            end
          end else begin
            cmd.wr_sel = WR_MARK;
            state_next = S_RESP;
          end
        end else if (sts.last) begin
          cmd.res_sel = RES_FAIL;
          state_next  = S_RESP;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.wr_sel = WR_SHIFT;
        if (sts.ptr_beyond) begin
          cmd.shift_step = 1'b1;
        end else begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.wr_sel = WR_TAIL;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.wr_sel = WR_HEAD;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* test/first_fit_block_allocator_test.sv */
`timescale 1ns / 1ps

module first_fit_block_allocator_test;
  import ffba_pkg::*;

  localparam int HDR = HEADER_BYTES_DEF;
  localparam int ARENA = ARENA_BYTES_DEF;
  localparam int MAXSEG = MAX_SEGMENTS_DEF;
  localparam int RANDOM_WORDS = 1032;
  localparam int SETTLE_CYCLES = 2 * MAXSEG + 8;

  typedef struct packed {
    status_t    status;
    logic [7:0] offset;
  } alloc_result_t;

  typedef struct packed {
    op_t           op;
    logic [7:0]    req;
    logic [7:0]    off;
    logic          typed;
    alloc_result_t res;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  int seg_start [MAXSEG];
  int seg_size [MAXSEG];
  bit seg_free [MAXSEG];
  int seg_count;

  alloc_result_t pending_results [$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  plan_row_t directed_plan [0:24] = '{
    '{OP_FREE,  8'd0,   8'd0,   1'b1, '{ST_NULL,     8'd0}},
    '{OP_FREE,  8'd0,   8'd255, 1'b1, '{ST_NOTFOUND, 8'd0}},
    '{OP_ALLOC, 8'd255, 8'd0,   1'b1, '{ST_NOFIT,    8'd0}},
    '{OP_ALLOC, 8'd209, 8'd0,   1'b1, '{ST_NOFIT,    8'd0}},
    '{OP_ALLOC, 8'd208, 8'd0,   1'b0, '{ST_OK,       8'd0}},
    '{OP_ALLOC, 8'd0,   8'd0,   1'b0, '{ST_OK,       8'd0}},
    '{OP_FREE,  8'd0,   8'd24,  1'b0, '{ST_OK,       8'd0}},
    '{OP_FREE,  8'd0,   8'd24,  1'b0, '{ST_OK,       8'd0}},
    '{OP_ALLOC, 8'd0,   8'd0,   1'b0, '{ST_OK,       8'd0}},
    '{OP_ALLOC, 8'd0,   8'd0,   1'b0, '{ST_OK,       8'd0}},
    '{OP_ALLOC, 8'd160, 8'd0,   1'b0, '{ST_OK,       8'd0}},
    '{OP_FREE,  8'd0,   8'd48,  1'b0, '{ST_OK,       8'd0}},
    '{OP_ALLOC, 8'd0,   8'd0,   1'b0, '{ST_OK,       8'd0}},
    '{OP_FREE,  8'd0,   8'd72,  1'b0, '{ST_OK,       8'd0}},
    '{OP_ALLOC, 8'd159, 8'd0,   1'b0, '{ST_OK,       8'd0}},
    '{OP_FREE,  8'd0,   8'd255, 1'b0, '{ST_OK,       8'd0}},
    '{OP_ALLOC, 8'd255, 8'd0,   1'b1, '{ST_NOFIT,    8'd0}},
    '{OP_FREE,  8'd0,   8'd254, 1'b1, '{ST_NOTFOUND, 8'd0}},
    '{OP_FREE,  8'd0,   8'd128, 1'b1, '{ST_NOTFOUND, 8'd0}},
    '{OP_FREE,  8'd0,   8'd24,  1'b0, '{ST_OK,       8'd0}},
    '{OP_ALLOC, 8'd127, 8'd0,   1'b0, '{ST_OK,       8'd0}},
    '{OP_FREE,  8'd0,   8'd1,   1'b1, '{ST_NOTFOUND, 8'd0}},
    '{OP_FREE,  8'd0,   8'd72,  1'b0, '{ST_OK,       8'd0}},
    '{OP_ALLOC, 8'd127, 8'd0,   1'b0, '{ST_OK,       8'd0}},
    '{OP_FREE,  8'd0,   8'd223, 1'b0, '{ST_OK,       8'd0}}
  };

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  first_fit_block_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic alloc_result_t apply_request(op_t op, logic [7:0] req, logic [7:0] off);
    int need;
    alloc_result_t res;
    need = int'(req) + HDR;
    res.offset = '0;
    if (op == OP_ALLOC) begin
      res.status = ST_NOFIT;
      for (int i = 0; i < seg_count; i++) begin
        if (seg_free[i] && seg_size[i] >= need) begin
          // split off the remainder while the table has room
          if (seg_size[i] >= need + 1 && seg_count < MAXSEG) begin
            for (int j = seg_count; j > i + 1; j--) begin
              seg_start[j] = seg_start[j-1];
              seg_size[j] = seg_size[j-1];
              seg_free[j] = seg_free[j-1];
            end
            seg_start[i+1] = seg_start[i] + need;
            seg_size[i+1] = seg_size[i] - need;
            seg_free[i+1] = 1'b1;
            seg_size[i] = int'(req);
            seg_count++;
          end
          seg_free[i] = 1'b0;
          res.status = ST_OK;
          res.offset = 8'(seg_start[i] + HDR);
          return res;
        end
      end
    end else if (off == '0) begin
      res.status = ST_NULL;
    end else begin
      res.status = ST_NOTFOUND;
      for (int i = 0; i < seg_count; i++) begin
        if (seg_start[i] + HDR == int'(off)) begin
          seg_free[i] = 1'b1;
          res.status = ST_OK;
          return res;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    err_count++;
  endtask

  task automatic send_word(op_t op, logic [7:0] req, logic [7:0] off, logic typed,
                           alloc_result_t typed_res);
    alloc_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {off, req};
    do @(posedge clk); while (!s_tready);
    res = apply_request(op, req, off);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 0, int'(m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] != want.status)
          report_mismatch("status", int'(want.status), int'(m_tdata[1:0]));
        if (m_tdata[9:2] != want.offset)
          report_mismatch("payload_offset", int'(want.offset), int'(m_tdata[9:2]));
      end
    end
  end

  initial begin
    alloc_result_t no_res;
    op_t op;
    logic [7:0] req;
    logic [7:0] off;
    int pick;
    no_res = '{ST_OK, 8'd0};
    for (int i = 0; i < MAXSEG; i++) begin
      seg_start[i] = 0;
      seg_size[i] = 0;
      seg_free[i] = 1'b0;
    end
    seg_size[0] = ARENA - HDR;
    seg_free[0] = 1'b1;
    seg_count = 1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 32;
    recv_stall_pct = 79;
    foreach (directed_plan[r])
      send_word(directed_plan[r].op, directed_plan[r].req, directed_plan[r].off,
                directed_plan[r].typed, directed_plan[r].res);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          recv_stall_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_stall_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (RANDOM_WORDS / 3) begin
        pick = $urandom_range(99);
        req = 8'($urandom_range(255));
        off = 8'($urandom_range(255));
        if (pick < 45) begin
          op = OP_ALLOC;
          req = 8'($urandom_range(48));
        end else if (pick < 55) begin
          op = OP_ALLOC;
        end else if (pick < 85) begin
          op = OP_FREE;
          off = 8'(seg_start[$urandom_range(seg_count - 1)] + HDR);
        end else if (pick < 93) begin
          op = OP_FREE;
        end else begin
          op = OP_FREE;
          off = '0;
        end
        send_word(op, req, off, 1'b0, no_res);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
